>>> sv/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared word width, operation codes and pipeline stage payload types for the
// floored / Euclidean signed divider.
// ----------------------------------------------------------------------------
package sfe_pkg;

    localparam int DATA_WIDTH = 32;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // rounding mode codes
    typedef enum logic {
        OP_FLOOR  = 1'b0,
        OP_EUCLID = 1'b1
    } t_op;

    // per-beat context that rides alongside the divide data
    typedef struct packed {
        t_op  op;
        logic sa;   // dividend negative
        logic sb;   // divisor negative
        logic dbz;  // divisor was zero
    } t_ctx;

    // payload of one divide stage
    typedef struct packed {
        t_ctx  ctx;
        t_word rem;  // partial remainder
        t_word quo;  // dividend bits shifting out, quotient bits shifting in
        t_word dvs;  // divisor magnitude
    } t_stage;

endpackage

>>> sv/sfe_prep.sv
// ----------------------------------------------------------------------------
// sfe_prep
// Input stage: takes signs and magnitudes of the operands and flags a zero
// divisor, loading the first register of the divide pipeline.
// ----------------------------------------------------------------------------
module sfe_prep import sfe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_ready,
    input  logic   i_op,
    input  t_word  i_dividend,
    input  t_word  i_divisor,
    output logic   o_valid,
    output t_stage o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic   sa;
    logic   sb;

    // register is free when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    // signs and magnitudes
    assign sa = i_dividend[DATA_WIDTH-1];
    assign sb = i_divisor[DATA_WIDTH-1];

    always_comb begin
        n_data.ctx.op  = t_op'(i_op);
        n_data.ctx.sa  = sa;
        n_data.ctx.sb  = sb;
        n_data.ctx.dbz = (i_divisor == '0);
        n_data.rem     = '0;
        n_data.quo     = sa ? t_word'(~i_dividend + t_word'(1)) : i_dividend;
        n_data.dvs     = sb ? t_word'(~i_divisor + t_word'(1)) : i_divisor;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/sfe_div_stage.sv
// ----------------------------------------------------------------------------
// sfe_div_stage
// One restoring division step: shifts one dividend bit into the partial
// remainder, trial-subtracts the divisor and records one quotient bit.
// ----------------------------------------------------------------------------
module sfe_div_stage import sfe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_ready,
    input  t_stage i_data,
    output logic   o_valid,
    output t_stage o_data
);

    logic                  r_valid;
    t_stage                r_data;
    t_stage                n_data;
    logic [DATA_WIDTH:0]   shift_val;
    logic [DATA_WIDTH:0]   diff_val;
    logic                  fits;

    assign o_ready = !r_valid || i_ready;

    // trial subtract; top bit of the difference is the borrow
    assign shift_val = {i_data.rem, i_data.quo[DATA_WIDTH-1]};
    assign diff_val  = shift_val - {1'b0, i_data.dvs};
    assign fits      = !diff_val[DATA_WIDTH];

    always_comb begin
        n_data     = i_data;
        n_data.rem = fits ? diff_val[DATA_WIDTH-1:0] : shift_val[DATA_WIDTH-1:0];
        n_data.quo = {i_data.quo[DATA_WIDTH-2:0], fits};
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/sfe_fixup.sv
// ----------------------------------------------------------------------------
// sfe_fixup
// Output stage: applies signs and the floored or Euclidean correction to the
// unsigned quotient and remainder, zeroes results on a zero divisor, and
// holds the result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module sfe_fixup import sfe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_stall,
    input  t_stage i_data,
    output logic   o_valid,
    output t_word  o_quotient,
    output t_word  o_remainder,
    output logic   o_divide_by_zero
);

    logic  r_valid;
    t_word r_quotient;
    t_word r_remainder;
    logic  r_dbz;
    t_op   r_op;
    logic  r_sb;
    t_word n_quotient;
    t_word n_remainder;

    t_word q_neg;
    t_word q_inc;
    t_word r_neg;
    t_word d_pos;
    t_word d_neg;
    logic  corr;

    assign o_ready = !r_valid || !i_stall;

    // candidate values, all in parallel
    assign q_neg = t_word'(~i_data.quo + t_word'(1));
    assign q_inc = t_word'(i_data.quo + t_word'(1));
    assign r_neg = t_word'(~i_data.rem + t_word'(1));
    assign d_pos = t_word'(i_data.dvs - i_data.rem);
    assign d_neg = t_word'(i_data.rem - i_data.dvs);

    // nonzero remainder needs a correction when its truncated sign is wrong
    always_comb begin
        corr = 1'b0;
        if (i_data.rem != '0) begin
            if (i_data.ctx.op == OP_FLOOR) begin
                corr = i_data.ctx.sa ^ i_data.ctx.sb;
            end else begin
                corr = i_data.ctx.sa;
            end
        end
    end

    // result select
    always_comb begin
        if (i_data.ctx.dbz) begin
            n_quotient  = '0;
            n_remainder = '0;
        end else if (!corr) begin
            n_quotient  = (i_data.ctx.sa ^ i_data.ctx.sb) ? q_neg : i_data.quo;
            n_remainder = i_data.ctx.sa ? r_neg : i_data.rem;
        end else begin
            // -q-1 is ~q; the same-sign case only arises in Euclidean mode
            n_quotient  = (i_data.ctx.sa ^ i_data.ctx.sb) ? ~i_data.quo : q_inc;
            n_remainder = i_data.ctx.sa ? d_pos : d_neg;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quotient  <= n_quotient;
            r_remainder <= n_remainder;
            r_dbz       <= i_data.ctx.dbz;
            r_op        <= i_data.ctx.op;
            r_sb        <= i_data.ctx.sb;
        end
    end

    assign o_valid          = r_valid;
    assign o_quotient       = r_quotient;
    assign o_remainder      = r_remainder;
    assign o_divide_by_zero = r_dbz;

    // zero divisor gives zero results
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_dbz |-> (r_quotient == '0) && (r_remainder == '0))
        else $error("zero divisor beat carries nonzero results");

    // Euclidean remainder is never negative
    a_euclid_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_dbz && (r_op == OP_EUCLID) |-> !r_remainder[DATA_WIDTH-1])
        else $error("Euclidean remainder negative");

    // floored nonzero remainder follows the divisor sign
    a_floor_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_dbz && (r_op == OP_FLOOR) && (r_remainder != '0)
        |-> (r_remainder[DATA_WIDTH-1] == r_sb))
        else $error("floored remainder sign differs from divisor sign");

endmodule

>>> sv/signed_divider_floor_euclid_unit.sv
// Throughput: one division per cycle unless i_stall backs up the pipeline;
// the restoring divider retires one quotient bit per pipeline stage,
// DATA_WIDTH stages in a row between the input and output registers.
// Each stage holds only while the one after it is full and held, so bubbles
// close up under output stall. Reset (synchronous, active low) clears all
// valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// signed_divider_floor_euclid_unit
// Pipelined signed divider giving quotient and remainder under floored or
// Euclidean rounding, with a divide-by-zero flag.
// ----------------------------------------------------------------------------
module signed_divider_floor_euclid_unit import sfe_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic signed [DATA_WIDTH-1:0] i_dividend,
    input  logic signed [DATA_WIDTH-1:0] i_divisor,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_quotient,
    output logic signed [DATA_WIDTH-1:0] o_remainder,
    output logic                         o_divide_by_zero
);

    t_stage stage_data  [0:DATA_WIDTH];
    logic   stage_valid [0:DATA_WIDTH];
    logic   stage_ready [0:DATA_WIDTH+1];
    t_word  quotient;
    t_word  remainder;

    // operand preparation
    sfe_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (stage_ready[0]),
        .i_ready    (stage_ready[1]),
        .i_op       (i_op),
        .i_dividend (t_word'(i_dividend)),
        .i_divisor  (t_word'(i_divisor)),
        .o_valid    (stage_valid[0]),
        .o_data     (stage_data[0])
    );

    assign o_stall = !stage_ready[0];

    // one quotient bit per stage
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_div
        sfe_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[k]),
            .o_ready (stage_ready[k+1]),
            .i_ready (stage_ready[k+2]),
            .i_data  (stage_data[k]),
            .o_valid (stage_valid[k+1]),
            .o_data  (stage_data[k+1])
        );
    end

    // sign correction and output register
    sfe_fixup u_fixup (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (stage_valid[DATA_WIDTH]),
        .o_ready          (stage_ready[DATA_WIDTH+1]),
        .i_stall          (i_stall),
        .i_data           (stage_data[DATA_WIDTH]),
        .o_valid          (o_valid),
        .o_quotient       (quotient),
        .o_remainder      (remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

    assign o_quotient  = quotient;
    assign o_remainder = remainder;

endmodule

>>> tb/sv/tb_signed_divider_floor_euclid_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_divider_floor_euclid_unit
// Self-checking bench for the pipelined floored / Euclidean signed divider.
// Directed corner divisions come first, then random operands. Both channels
// get random idle bursts, and one long output hold backs up the pipeline. Each
// result beat is checked field by field against a behavioral divide model, in
// order of acceptance.
// ----------------------------------------------------------------------------
module tb_signed_divider_floor_euclid_unit import sfe_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = DATA_WIDTH + 8;
    localparam t_word WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_word WORD_MAX = ~WORD_MIN;

    typedef struct {
        t_word quotient;
        t_word remainder;
        logic  divide_by_zero;
    } t_division;

    // expected-result store plus the divide model
    class t_division_scoreboard;
        t_division   expected_q[$];
        int unsigned mismatches = 0;

        function t_division predict_division(t_op op, t_word a, t_word b);
            t_division res;
            logic      sa;
            logic      sb;
            t_word     ua;
            t_word     ub;
            t_word     q0;
            t_word     r0;
            res.divide_by_zero = 1'b0;
            if (b == '0) begin
                res.quotient = '0;
                res.remainder = '0;
                res.divide_by_zero = 1'b1;
                return res;
            end
            sa = a[DATA_WIDTH-1];
            sb = b[DATA_WIDTH-1];
            ua = sa ? -a : a;
            ub = sb ? -b : b;
            q0 = ua / ub;
            r0 = ua % ub;
            // truncated result first
            res.quotient = (sa != sb) ? -q0 : q0;
            res.remainder = sa ? -r0 : r0;
            // then shift toward the selected rounding when inexact
            if (r0 != '0) begin
                if (op == OP_FLOOR) begin
                    if (sa != sb) begin
                        res.quotient = res.quotient - 1'b1;
                        res.remainder = res.remainder + b;
                    end
                end else if (sa) begin
                    if (!sb) begin
                        res.quotient = res.quotient - 1'b1;
                        res.remainder = res.remainder + b;
                    end else begin
                        res.quotient = res.quotient + 1'b1;
                        res.remainder = res.remainder - b;
                    end
                end
            end
            return res;
        endfunction

        function void note_operands(t_op op, t_word a, t_word b);
            expected_q.push_back(predict_division(op, a, b));
        endfunction

        function void check_result(t_word q, t_word r, logic dbz);
            t_division exp_res;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: quotient %0d remainder %0d",
                       $signed(q), $signed(r));
                mismatches++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (q !== exp_res.quotient) begin
                $error("quotient: expected %0d, got %0d",
                       $signed(exp_res.quotient), $signed(q));
                mismatches++;
            end
            if (r !== exp_res.remainder) begin
                $error("remainder: expected %0d, got %0d",
                       $signed(exp_res.remainder), $signed(r));
                mismatches++;
            end
            if (dbz !== exp_res.divide_by_zero) begin
                $error("divide_by_zero: expected %0b, got %0b",
                       exp_res.divide_by_zero, dbz);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_op;
    logic signed [DATA_WIDTH-1:0] i_dividend;
    logic signed [DATA_WIDTH-1:0] i_divisor;
    logic                         o_valid;
    logic                         i_stall;
    logic signed [DATA_WIDTH-1:0] o_quotient;
    logic signed [DATA_WIDTH-1:0] o_remainder;
    logic                         o_divide_by_zero;

    t_division_scoreboard div_board = new();
    int unsigned          cycle_count = 0;
    int unsigned          out_stall_pct = 0;
    bit                   hold_output = 1'b0;

    signed_divider_floor_euclid_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_quotient       (o_quotient),
        .o_remainder      (o_remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_divider_floor_euclid_unit verification failed");
            $finish;
        end
    end

    // result beats checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            div_board.check_result(o_quotient, o_remainder, o_divide_by_zero);
        end
    end

    // output-side stall: random bursts, or one long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_output = 1'b0;
            end else if ($urandom_range(1, 100) <= out_stall_pct) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // offer one division beat and hold it until accepted
    task automatic send_division(input t_op op, input t_word a, input t_word b);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_op = op;
        i_dividend = a;
        i_divisor = b;
        do @(posedge i_clk); while (o_stall);
        div_board.note_operands(op, a, b);
    endtask

    // input bubbles; payload is junk while valid is low
    task automatic idle_input(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_op = 1'($urandom);
            i_dividend = $urandom;
            i_divisor = $urandom;
        end
    endtask

    // operand mix: full range, extremes, small magnitudes and zero
    function automatic t_word pick_operand();
        case ($urandom_range(0, 11))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2, 3: return t_word'(int'($urandom_range(0, 40)) - 20);
            4: return $urandom_range(0, 1) ? t_word'(1) : t_word'(-1);
            5: return '0;
            6: return t_word'($urandom) >> $urandom_range(1, DATA_WIDTH - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic feed_random(input int unsigned count, input int unsigned gap_pct);
        t_op op;
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(1, 100) <= gap_pct) begin
                idle_input($urandom_range(1, 17));
            end
            op = $urandom_range(0, 1) ? OP_EUCLID : OP_FLOOR;
            send_division(op, pick_operand(), pick_operand());
        end
    endtask

    task automatic wait_drained();
        while (div_board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = OP_FLOOR;
        i_dividend = '0;
        i_divisor = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: sign combinations in both modes
        for (int m = 0; m < 2; m++) begin
            send_division(t_op'(m), 7, 2);
            send_division(t_op'(m), -7, 2);
            send_division(t_op'(m), 7, -2);
            send_division(t_op'(m), -7, -2);
        end
        // zero divisor, overflow wrap, extremes, exact divisions
        send_division(OP_FLOOR, 5, 0);
        send_division(OP_EUCLID, WORD_MIN, 0);
        send_division(OP_FLOOR, WORD_MIN, -1);
        send_division(OP_EUCLID, WORD_MIN, -1);
        send_division(OP_FLOOR, WORD_MAX, 1);
        send_division(OP_EUCLID, WORD_MIN, WORD_MIN);
        send_division(OP_FLOOR, WORD_MAX, WORD_MIN);
        send_division(OP_EUCLID, WORD_MIN, WORD_MAX);
        send_division(OP_FLOOR, WORD_MIN, WORD_MAX);
        send_division(OP_EUCLID, -1, WORD_MIN);
        send_division(OP_FLOOR, 0, -1);
        send_division(OP_EUCLID, -6, 3);
        send_division(OP_FLOOR, 6, -3);
        send_division(OP_EUCLID, -1, WORD_MAX);

        // random with bubbles on both sides
        out_stall_pct = 15;
        feed_random(600, 20);

        // long output hold while input keeps coming: pipeline fills and stalls
        hold_output = 1'b1;
        feed_random(80, 0);
        // drop valid before pausing so no beat is offered twice
        idle_input(1);
        wait_drained();
        idle_input($urandom_range(1, 17));

        out_stall_pct = 25;
        feed_random(780, 30);

        // closing stretch back to back, no bubbles
        out_stall_pct = 0;
        feed_random(220, 0);
        idle_input(1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (div_board.mismatches == 0 && div_board.pending() == 0) begin
            $display("signed_divider_floor_euclid_unit verification clean");
        end else begin
            $display("signed_divider_floor_euclid_unit verification failed");
        end
        $finish;
    end

endmodule
